// ===== src/bsmv_pkg.sv =====
package bsmv_pkg;

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_ENTRY = 2'd1;
   localparam logic [1:0] OP_EMIT  = 2'd2;

   // field widths
   localparam int OP_W    = 2;
   localparam int IDX_W   = 6;
   localparam int CFG_W   = 7;
   localparam int VAL_W   = 32;
   localparam int SUM_W   = 48;
   localparam int PROD_W  = 64;
   localparam int REQ_W   = 64;
   localparam int RSP_W   = 56;

   // vector positions reachable by a 6-bit index
   localparam int VEC_SLOTS = 64;

   // largest value a size register can hold
   localparam logic [CFG_W-1:0] CFG_MAX = 7'd127;

   // register indexes on the csr port
   localparam logic CSR_ROW_COUNT    = 1'b0;
   localparam logic CSR_COLUMN_COUNT = 1'b1;

   // rounding bias for Q32.32 to Q32.16
   localparam logic signed [PROD_W-1:0] ROUND_BIAS = 64'sd32768;

   // saturation bounds of a Q32.16 sum
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // request beat payload, last field in the lowest bits
   typedef struct packed {
      logic [1:0]              pad;
      logic signed [VAL_W-1:0] value;
      logic [IDX_W-1:0]        local_col;
      logic [IDX_W-1:0]        local_row;
      logic [IDX_W-1:0]        block_col_start;
      logic [IDX_W-1:0]        block_row_start;
      logic [IDX_W-1:0]        vector_index;
   } req_data_type;

   // response beat payload, last field in the lowest bits
   typedef struct packed {
      logic [1:0]              pad;
      logic signed [SUM_W-1:0] result_value;
      logic [IDX_W-1:0]        row_index;
   } rsp_data_type;

endpackage

// ===== src/block_sparse_matrix_vector_multiply.sv =====
// channel   direction  beat contents
// req_      in         tuser: operation; tdata: vector_index, block_row_start,
//                      block_col_start, local_row, local_col, value
// rsp_      out        tdata: row_index, result_value; tlast: last_row;
//                      tuser: size_error
// csr_      in         we, index, wdata: row_count (0), column_count (1)
//
// a vector load writes the vector memory, a block entry passes a memory read,
// a multiply, and a round and saturating add with write-back into the row sum memory
// an emit walks the row sum memory one row per cycle while rsp_ is not stalled, one read port sets it
// reset clears control and the valid bits of both memories and sets both size registers to 64
// a stalled rsp_ holds one row in the read register and then blocks req_

module block_sparse_matrix_vector_multiply
   import bsmv_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // vector_index, block_row_start, block_col_start,
                                         // local_row, local_col, value
   input  logic [OP_W-1:0]  req_tuser,   // operation
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // row_index, result_value
   output logic             rsp_tlast,
   output logic             rsp_tuser,   // size_error
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int VDEPTH = (MAX_COLS < VEC_SLOTS) ? MAX_COLS : VEC_SLOTS;
   localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
   localparam int RAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam logic [CFG_W-1:0] ROW_LIMIT = CFG_W'(MAX_ROWS);
   localparam logic [CFG_W-1:0] COL_LIMIT =
      (MAX_COLS < int'(CFG_MAX)) ? CFG_W'(MAX_COLS) : CFG_MAX;
   localparam logic [CFG_W-1:0] VEC_LIMIT = CFG_W'(VDEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_ACC  = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   // memories
   logic signed [VAL_W-1:0] vec_mem [VDEPTH];
   logic signed [SUM_W-1:0] sum_mem [MAX_ROWS];

   // control registers
   logic [1:0]          state_ff, state_in;
   logic [VDEPTH-1:0]   vvalid_ff, vvalid_in;
   logic [MAX_ROWS-1:0] svalid_ff, svalid_in;
   logic                err_ff, err_in;
   logic                rd_pend_ff, rd_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    row_cnt_ff, row_cnt_in;
   logic [CFG_W-1:0]    row_count_ff, column_count_ff;

   // payload registers
   logic signed [VAL_W-1:0]  vec_q_ff;
   logic                     vec_hit_ff;
   logic signed [SUM_W-1:0]  sum_q_ff;
   logic                     sum_hit_ff;
   logic signed [VAL_W-1:0]  val_ff;
   logic [RAW-1:0]           row_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [IDX_W-1:0]         pend_row_ff;
   logic                     pend_last_ff;
   logic                     pend_err_ff;
   logic [IDX_W-1:0]         rsp_row_ff;
   logic signed [SUM_W-1:0]  rsp_val_ff;
   logic                     rsp_last_ff;
   logic                     rsp_err_ff;

   req_data_type            req;
   logic                    accept;
   logic [CFG_W-1:0]        used_rows, used_cols;
   logic [CFG_W-1:0]        row_sum, col_sum;
   logic                    load_ok, entry_ok;
   logic                    load_go, entry_go;
   logic                    emit_issue, emit_last, pend_load;
   logic                    sum_re, sum_we;
   logic [RAW-1:0]          sum_addr;
   logic signed [VAL_W-1:0] elem;
   logic signed [PROD_W-1:0] prod_in, rnd_full;
   logic signed [SUM_W-1:0] rnd, acc, sat;
   logic [SUM_W:0]          sum_wide;

   // field decode and effective sizes
   assign req       = req_data_type'(req_tdata);
   assign used_rows = (row_count_ff < ROW_LIMIT) ? row_count_ff : ROW_LIMIT;
   assign used_cols = (column_count_ff < COL_LIMIT) ? column_count_ff : COL_LIMIT;
   assign row_sum   = CFG_W'(req.block_row_start) + CFG_W'(req.local_row);
   assign col_sum   = CFG_W'(req.block_col_start) + CFG_W'(req.local_col);
   assign load_ok   = CFG_W'(req.vector_index) < used_cols;
   assign entry_ok  = (row_sum < used_rows) && (col_sum < used_cols);

   // handshake
   assign req_tready = (state_ff == S_IDLE) && !rd_pend_ff;
   assign accept     = req_tvalid && req_tready;
   assign load_go    = accept && (req_tuser == OP_LOAD) && load_ok;
   assign entry_go   = accept && (req_tuser == OP_ENTRY) && entry_ok;

   // emit walk: one read per cycle while the read register drains
   assign pend_load  = rd_pend_ff && (!rsp_valid_ff || rsp_tready);
   assign emit_issue = (state_ff == S_EMIT) && (!rd_pend_ff || pend_load);
   assign emit_last  = (CFG_W'(row_cnt_ff) + CFG_W'(1)) == used_rows;

   // row sum memory port select
   assign sum_re   = entry_go || emit_issue;
   assign sum_addr = (state_ff == S_EMIT) ? row_cnt_ff[RAW-1:0] : row_sum[RAW-1:0];
   assign sum_we   = (state_ff == S_ACC);

   // multiply, round, saturating add
   assign elem     = vec_hit_ff ? vec_q_ff : '0;
   assign prod_in  = PROD_W'(val_ff) * PROD_W'(elem);
   assign rnd_full = prod_ff + ROUND_BIAS;
   assign rnd      = rnd_full[PROD_W-1:16];
   assign acc      = sum_hit_ff ? sum_q_ff : '0;
   assign sum_wide = {acc[SUM_W-1], acc} + {rnd[SUM_W-1], rnd};
   assign sat      = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                     ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX)
                     : sum_wide[SUM_W-1:0];

   // sequencer and flags
   always_comb begin
      state_in     = state_ff;
      vvalid_in    = vvalid_ff;
      svalid_in    = svalid_ff;
      err_in       = err_ff;
      row_cnt_in   = row_cnt_ff;
      rd_pend_in   = rd_pend_ff;
      rsp_valid_in = rsp_valid_ff;
      if (pend_load) begin
         rd_pend_in = 1'b0;
      end
      if (emit_issue) begin
         rd_pend_in = 1'b1;
      end
      if (pend_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  OP_LOAD: begin
                     if (load_ok) begin
                        vvalid_in[req.vector_index[VAW-1:0]] = 1'b1;
                     end else begin
                        err_in = 1'b1;
                     end
                  end
                  OP_ENTRY: begin
                     if (entry_ok) begin
                        state_in = S_MUL;
                     end else begin
                        err_in = 1'b1;
                     end
                  end
                  OP_EMIT: begin
                     if (used_rows == '0) begin
                        svalid_in = '0;
                        err_in    = 1'b0;
                     end else begin
                        state_in   = S_EMIT;
                        row_cnt_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            svalid_in[row_ff] = 1'b1;
            state_in          = S_IDLE;
         end
         S_EMIT: begin
            if (emit_issue) begin
               row_cnt_in = row_cnt_ff + IDX_W'(1);
               if (emit_last) begin
                  state_in  = S_IDLE;
                  svalid_in = '0;
                  err_in    = 1'b0;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         vvalid_ff       <= '0;
         svalid_ff       <= '0;
         err_ff          <= 1'b0;
         row_cnt_ff      <= '0;
         rd_pend_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         row_count_ff    <= CFG_W'(64);
         column_count_ff <= CFG_W'(64);
      end else begin
         state_ff     <= state_in;
         vvalid_ff    <= vvalid_in;
         svalid_ff    <= svalid_in;
         err_ff       <= err_in;
         row_cnt_ff   <= row_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ROW_COUNT:    row_count_ff    <= csr_wdata;
               CSR_COLUMN_COUNT: column_count_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // vector store
   always_ff @(posedge clock) begin
      if (load_go) begin
         vec_mem[req.vector_index[VAW-1:0]] <= req.value;
      end
      if (accept && (req_tuser == OP_ENTRY)) begin
         vec_q_ff   <= vec_mem[col_sum[VAW-1:0]];
         vec_hit_ff <= (col_sum < VEC_LIMIT) && vvalid_ff[col_sum[VAW-1:0]];
         val_ff     <= req.value;
         row_ff     <= row_sum[RAW-1:0];
      end
   end

   // row sum memory
   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[row_ff] <= sat;
      end
      if (sum_re) begin
         sum_q_ff   <= sum_mem[sum_addr];
         sum_hit_ff <= svalid_ff[sum_addr];
      end
   end

   // product register
   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         prod_ff <= prod_in;
      end
   end

   // emit read tags and output register
   always_ff @(posedge clock) begin
      if (emit_issue) begin
         pend_row_ff  <= row_cnt_ff;
         pend_last_ff <= emit_last;
         pend_err_ff  <= err_ff;
      end
      if (pend_load) begin
         rsp_row_ff  <= pend_row_ff;
         rsp_val_ff  <= acc;
         rsp_last_ff <= pend_last_ff;
         rsp_err_ff  <= pend_err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_type'{pad: '0, result_value: rsp_val_ff,
                                      row_index: rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

`ifndef SYNTHESIS
   // input is held off whenever the sequencer is busy
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request accepted while sequencer busy");

   // a multiply is always followed by its write-back
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |=> (state_ff == S_ACC))
      else $error("multiply not followed by accumulate");

   // the last row of a run is the final used row
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> ((CFG_W'(rsp_row_ff) + CFG_W'(1)) == used_rows))
      else $error("last row flag on wrong row");

   // no write-back while the emit walk reads the sums
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> !sum_we)
      else $error("row sum written during emit");
`endif

endmodule
